>>> src/cab64_pkg.sv
// ----------------------------------------------------------------------------
// cab64_pkg: shared definitions for the shuffled-alphabet Base64 encoder
// Holds the symbol alphabet, padding code, group sizes and the group type
// passed from the packing stage to the symbol serialiser.
// ----------------------------------------------------------------------------
package cab64_pkg;

  localparam int unsigned SymW      = 8;
  localparam int unsigned SextetW   = 6;
  localparam int unsigned GroupSyms = 4;
  localparam int unsigned IdxW      = $clog2(GroupSyms);

  localparam logic [IdxW-1:0] LastIdx   = IdxW'(GroupSyms - 1);
  localparam logic [SymW-1:0] PadSymbol = 8'h3D;

  // Character k of the alphabet sits at bits [(63-k)*8 +: 8].
  localparam logic [64*SymW-1:0] Alphabet =
    "9+#FvwxNG78pqrghijCDEWXy4oAd56kQHlmBuOPYz0cstef1IJKLM23ZabnRSTUV";

  // Four symbols of one request, entry 0 leaves first.
  typedef struct packed {
    logic [GroupSyms-1:0][SymW-1:0] sym;
    logic                           fin;
  } cab64_grp_t;

  // Map a sextet to its ASCII symbol; 63 - s equals ~s on six bits.
  function automatic logic [SymW-1:0] sym_of(logic [SextetW-1:0] s);
    return Alphabet[{~s, 3'b000} +: SymW];
  endfunction

endpackage

>>> src/cab64_if.sv
// ----------------------------------------------------------------------------
// cab64_if: request channels of the shuffled-alphabet Base64 encoder
// Byte channel in, symbol channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface cab64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface cab64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, symbol, run_last, stream_done, input ready);
  modport sink   (input valid, symbol, run_last, stream_done, output ready);
endinterface

>>> src/cab64_pack.sv
// ----------------------------------------------------------------------------
// cab64_pack: byte collection and symbol group formation
// Holds up to two pending bytes and registers a four-symbol group whenever a
// byte completes a triple or ends the stream with a tail to pad.
// ----------------------------------------------------------------------------
module cab64_pack (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  cab64_in_if.sink               in_i,
  output logic                   grp_valid_o,
  output cab64_pkg::cab64_grp_t  grp_o,
  input  logic                   grp_take_i
);

  logic [15:0]           pend_q, pend_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  grp_valid_q, grp_valid_d;
  cab64_pkg::cab64_grp_t grp_q, grp_d;

  logic        accept;
  logic        emit;
  logic [23:0] word;
  logic [15:0] pend_next;
  logic [1:0]  cnt_next;

  assign in_i.ready = !grp_valid_q || grp_take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    word      = {pend_q, in_i.data_byte};
    pend_next = {pend_q[7:0], in_i.data_byte};
    cnt_next  = cnt_q + 2'd1;
    emit      = 1'b0;
    grp_d     = grp_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;

    grp_d.fin = in_i.final_byte;
    if (cnt_q[1]) begin
      // Triple complete: middle sextets swapped.
      emit          = 1'b1;
      grp_d.sym[0]  = cab64_pkg::sym_of(word[23:18]);
      grp_d.sym[1]  = cab64_pkg::sym_of(word[11:6]);
      grp_d.sym[2]  = cab64_pkg::sym_of(word[17:12]);
      grp_d.sym[3]  = cab64_pkg::sym_of(word[5:0]);
      pend_d        = '0;
      cnt_d         = '0;
    end else if (in_i.final_byte) begin
      emit   = 1'b1;
      pend_d = '0;
      cnt_d  = '0;
      if (cnt_next == 2'd1) begin
        grp_d.sym[0] = cab64_pkg::sym_of(pend_next[7:2]);
        grp_d.sym[1] = cab64_pkg::sym_of({pend_next[1:0], 4'b0000});
        grp_d.sym[2] = cab64_pkg::PadSymbol;
        grp_d.sym[3] = cab64_pkg::PadSymbol;
      end else begin
        grp_d.sym[0] = cab64_pkg::sym_of(pend_next[15:10]);
        grp_d.sym[1] = cab64_pkg::sym_of(pend_next[9:4]);
        grp_d.sym[2] = cab64_pkg::sym_of({pend_next[3:0], 2'b00});
        grp_d.sym[3] = cab64_pkg::PadSymbol;
      end
    end else begin
      pend_d = pend_next;
      cnt_d  = cnt_next;
    end

    if (!accept) begin
      pend_d = pend_q;
      cnt_d  = cnt_q;
      grp_d  = grp_q;
    end

    if (accept && emit) begin
      grp_valid_d = 1'b1;
    end else if (grp_take_i) begin
      grp_valid_d = 1'b0;
    end else begin
      grp_valid_d = grp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      cnt_q       <= '0;
      grp_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      grp_valid_q <= grp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_valid_o = grp_valid_q;
  assign grp_o       = grp_q;

endmodule

>>> src/cab64_ser.sv
// ----------------------------------------------------------------------------
// cab64_ser: symbol serialiser
// Takes one four-symbol group and presents its symbols one per request.
// ----------------------------------------------------------------------------
module cab64_ser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   grp_valid_i,
  input  cab64_pkg::cab64_grp_t  grp_i,
  output logic                   grp_take_o,
  cab64_out_if.source            out_o
);

  logic                                                     busy_q, busy_d;
  logic [cab64_pkg::IdxW-1:0]                               idx_q, idx_d;
  logic [cab64_pkg::GroupSyms-1:0][cab64_pkg::SymW-1:0]     sym_q, sym_d;
  logic                                                     fin_q, fin_d;

  logic fire;
  logic at_last;
  logic free;

  assign at_last    = (idx_q == cab64_pkg::LastIdx);
  assign fire       = busy_q && out_o.ready;
  assign free       = !busy_q || (fire && at_last);
  assign grp_take_o = grp_valid_i && free;

  assign out_o.valid       = busy_q;
  assign out_o.symbol      = sym_q[idx_q];
  assign out_o.run_last    = at_last;
  assign out_o.stream_done = at_last && fin_q;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    sym_d  = sym_q;
    fin_d  = fin_q;
    if (grp_take_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
      sym_d  = grp_i.sym;
      fin_d  = grp_i.fin;
    end else if (fire) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    fin_q <= fin_d;
  end

endmodule

>>> src/custom_alphabet_base64_encoder_unit.sv
// ----------------------------------------------------------------------------
// custom_alphabet_base64_encoder_unit: shuffled-alphabet Base64 encoder
// Bytes in, ASCII symbols out, one request per cycle each side unless stalled.
// ----------------------------------------------------------------------------
// A byte that neither completes a triple nor ends the stream is taken and
// produces nothing. A byte that completes a triple produces four
// symbols with the two middle sextets swapped; a final byte that leaves one
// or two bytes pending produces the tail in normal sextet order padded with
// '=' to four symbols. run_last marks the fourth symbol of each group and
// stream_done marks it too when the group closes the stream. After a final
// byte the unit starts a fresh stream. Throughput is set by the output port,
// which moves one symbol per cycle while ready is high; a triple of bytes
// becomes four output symbols, and a byte is taken every cycle while the
// group register is free. An emitting byte travels to the output through
// the group register, then the serialiser.
// ----------------------------------------------------------------------------
module custom_alphabet_base64_encoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  cab64_in_if.sink     in_i,
  cab64_out_if.source  out_o
);

  logic                  grp_valid;
  logic                  grp_take;
  cab64_pkg::cab64_grp_t grp;

  // Collect bytes and form a registered group of four symbols.
  cab64_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp),
    .grp_take_i  (grp_take)
  );

  // Hand the group out one symbol per request; take the next group on the
  // cycle its last symbol leaves.
  cab64_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .grp_take_o  (grp_take),
    .out_o       (out_o)
  );

endmodule
